### rtl/core/envnd_pkg.sv
// Shared types and constants of the envelope-normalizing distortion block.
package envnd_pkg;

    // Fixed register and state widths.
    localparam int ENV_W     = 24;
    localparam int KNEE_W    = 21;
    localparam int COEF_W    = 16;
    localparam int TAPS_W    = 4;
    localparam int CFG_W     = 21;
    localparam int IDX_W     = 2;

    // The gain of ten and the Q4.20 scale meet in one shift by 21 bits.
    localparam int NUM_SHIFT = 21;

    // Largest gained magnitude: ten times full scale in Q4.20.
    localparam logic [ENV_W-1:0] ENV_MAX = 24'd10485760;

    // Register reset values.
    localparam logic [KNEE_W-1:0] KNEE_RST = 21'd1048576;
    localparam logic [COEF_W-1:0] COEF_RST = 16'd4369;
    localparam logic [TAPS_W-1:0] TAPS_RST = 4'd8;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_KNEE = 2'd0;
    localparam logic [IDX_W-1:0] REG_COEF = 2'd1;
    localparam logic [IDX_W-1:0] REG_TAPS = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_ENV,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

### rtl/core/envelope_normalizing_distortion.sv
// Envelope-normalizing distortion: follower, delay ring, serial multiply and divide.
//
// Usage: one signed Q1.15 sample enters on the input channel (i_in_valid, o_in_stall)
// and one result (o_sample_out, o_clipped) leaves on the output channel (o_out_valid,
// i_out_stall). Each channel transfers at a clock edge where valid is high and stall
// is low. The block works on one sample at a time; o_in_stall is high while it does.
// The envelope release step is a bit-serial shift-add multiply over the 16 bits of the
// release coefficient, and the normalizing divide is a restoring divider that takes one
// quotient bit per cycle over SAMPLE_WIDTH+21 numerator bits.
// An attacking envelope skips the release multiply: a sample then passes LOAD, PREP,
// DIV and FIN, while a releasing envelope passes LOAD, MUL, ENV, PREP, DIV and FIN.
// The next input transfer is taken only back in idle, once the current sample leaves
// the last step, so the block finishes one sample before it takes the next.
// A finished result sits in the output register; the next sample is accepted and
// processed while it waits, and that next result holds in the last step until the
// output register is free. Configuration writes are taken at any edge with i_cfg_we
// but are meant for idle periods only.
// Synchronous reset clears the envelope, the write pointer and the ring's valid bits,
// so the ring reads as zeros, and loads the register reset values.
module envelope_normalizing_distortion
    import envnd_pkg::*;
#(
    parameter int RING_DEPTH   = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port
    input  logic                           i_cfg_we,
    input  logic [IDX_W-1:0]               i_cfg_idx,
    input  logic [CFG_W-1:0]               i_cfg_data,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    // Output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_clipped
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int NUM_W = SAMPLE_WIDTH + NUM_SHIFT;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int UP_W  = NUM_SHIFT + 4;

    // Tap count reduced modulo the ring depth, as a small constant table.
    function automatic logic [PTR_W-1:0] f_tap_mod(input logic [TAPS_W-1:0] t);
        logic [PTR_W-1:0] r;
        r = '0;
        for (int k = 0; k < (1 << TAPS_W); k++) begin
            if (t == TAPS_W'(k)) begin
                r = PTR_W'(k % RING_DEPTH);
            end
        end
        return r;
    endfunction

    // Control and state registers.
    t_state                  r_state;
    t_state                  n_state;
    logic [KNEE_W-1:0]       r_knee;
    logic [COEF_W-1:0]       r_coef;
    logic [TAPS_W-1:0]       r_taps;
    logic [ENV_W-1:0]        r_env;
    logic [PTR_W-1:0]        r_wp;
    logic [RING_DEPTH-1:0]   r_valid;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_out_valid;

    // Datapath registers.
    logic [SAMPLE_WIDTH-1:0] r_ring [RING_DEPTH];
    logic [SAMPLE_WIDTH-1:0] r_ring_q;
    logic                    r_ring_vld;
    logic [PTR_W-1:0]        r_rd_ptr;
    logic [ENV_W-1:0]        r_mag;
    logic [ENV_W-1:0]        r_diff;
    logic [ENV_W-1:0]        r_acc;
    logic                    r_rbit;
    logic [COEF_W-1:0]       r_coef_sh;
    logic [ENV_W-1:0]        r_div;
    logic [NUM_W-1:0]        r_num;
    logic [ENV_W-1:0]        r_rem;
    logic [SAMPLE_WIDTH-1:0] r_quo;
    logic                    r_ovf;
    logic                    r_neg;
    logic [SAMPLE_WIDTH-1:0] r_sample_out;
    logic                    r_clipped;

    logic                    w_in_xfer;
    logic                    w_out_load;
    logic                    w_out_xfer;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = r_out_valid && !i_out_stall;
    assign w_out_load = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);

    // Gained magnitude of the incoming sample in Q4.20.
    logic [SAMPLE_WIDTH-1:0] w_abs_in;
    logic [SAMPLE_WIDTH+3:0] w_mag10;
    logic [ENV_W-1:0]        w_mag;

    assign w_abs_in = i_sample_in[SAMPLE_WIDTH-1] ? (~i_sample_in + 1'b1) : i_sample_in;
    assign w_mag10  = ((SAMPLE_WIDTH+4)'(w_abs_in) << 3) + ((SAMPLE_WIDTH+4)'(w_abs_in) << 1);

    generate
        if (SAMPLE_WIDTH <= NUM_SHIFT) begin : g_gain_up
            logic [UP_W-1:0] w_up;
            assign w_up  = UP_W'(w_mag10) << (NUM_SHIFT - SAMPLE_WIDTH);
            assign w_mag = w_up[ENV_W-1:0];
        end else begin : g_gain_down
            assign w_mag = ENV_W'(w_mag10 >> (SAMPLE_WIDTH - NUM_SHIFT));
        end
    endgenerate

    // Read pointer: write pointer minus the tap count, modulo the ring depth.
    logic [PTR_W:0]   w_rd_sum;
    logic [PTR_W-1:0] w_rd_ptr;
    logic [PTR_W-1:0] w_wp_next;

    assign w_rd_sum  = (PTR_W+1)'(r_wp) + (PTR_W+1)'(RING_DEPTH) - (PTR_W+1)'(f_tap_mod(r_taps));
    assign w_rd_ptr  = (w_rd_sum >= (PTR_W+1)'(RING_DEPTH)) ?
                       PTR_W'(w_rd_sum - (PTR_W+1)'(RING_DEPTH)) : w_rd_sum[PTR_W-1:0];
    assign w_wp_next = (r_wp == PTR_W'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;

    // One shift-add step of the release multiply.
    logic [ENV_W:0] w_mul_sum;
    assign w_mul_sum = {1'b0, r_acc} + (r_coef_sh[0] ? {1'b0, r_diff} : '0);

    // Divisor, delayed sample and rounded numerator.
    logic [ENV_W-1:0]        w_div;
    logic [SAMPLE_WIDTH-1:0] w_xd;
    logic [SAMPLE_WIDTH-1:0] w_xd_abs;
    logic [NUM_W-1:0]        w_num;

    assign w_div    = (r_env > ENV_W'(r_knee)) ? r_env : ENV_W'(r_knee);
    assign w_xd     = r_ring_vld ? r_ring_q : '0;
    assign w_xd_abs = w_xd[SAMPLE_WIDTH-1] ? (~w_xd + 1'b1) : w_xd;
    assign w_num    = (NUM_W'(w_xd_abs) << NUM_SHIFT) + NUM_W'(w_div >> 1);

    // One restoring divide step.
    logic [ENV_W:0] w_trial;
    logic           w_ge;
    logic [ENV_W:0] w_trial_sub;

    assign w_trial     = {r_rem, r_num[NUM_W-1]};
    assign w_ge        = (w_trial >= {1'b0, r_div});
    assign w_trial_sub = w_trial - {1'b0, r_div};

    // Saturation and sign of the final quotient.
    logic [SAMPLE_WIDTH-1:0] w_res;
    logic                    w_clip;

    always_comb begin
        w_res  = '0;
        w_clip = 1'b0;
        if (r_div == '0) begin
            w_clip = 1'b1;
        end else if (r_neg) begin
            if (r_ovf || (r_quo[SAMPLE_WIDTH-1] && (|r_quo[SAMPLE_WIDTH-2:0]))) begin
                w_res  = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
                w_clip = 1'b1;
            end else begin
                w_res = ~r_quo + 1'b1;
            end
        end else begin
            if (r_ovf || r_quo[SAMPLE_WIDTH-1]) begin
                w_res  = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
                w_clip = 1'b1;
            end else begin
                w_res = r_quo;
            end
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = (r_mag > r_env) ? ST_PREP : ST_MUL;
            end
            ST_MUL: begin
                if (r_cnt == CNT_W'(COEF_W - 1)) begin
                    n_state = ST_ENV;
                end
            end
            ST_ENV:  n_state = ST_PREP;
            ST_PREP: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers, configuration, envelope and ring bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_knee      <= KNEE_RST;
            r_coef      <= COEF_RST;
            r_taps      <= TAPS_RST;
            r_env       <= '0;
            r_wp        <= '0;
            r_valid     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KNEE: r_knee <= i_cfg_data[KNEE_W-1:0];
                    REG_COEF: r_coef <= i_cfg_data[COEF_W-1:0];
                    REG_TAPS: r_taps <= i_cfg_data[TAPS_W-1:0];
                    default:  ;
                endcase
            end

            if (w_in_xfer) begin
                r_valid[r_wp] <= 1'b1;
                r_wp          <= w_wp_next;
            end

            // Attack jumps to the magnitude; release subtracts the rounded product.
            if (r_state == ST_LOAD && r_mag > r_env) begin
                r_env <= r_mag;
            end else if (r_state == ST_ENV) begin
                r_env <= r_env - (r_acc + ENV_W'(r_rbit));
            end

            if (r_state == ST_MUL || r_state == ST_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers and the delay ring.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_ring[r_wp] <= i_sample_in;
            r_mag        <= w_mag;
            r_rd_ptr     <= w_rd_ptr;
        end

        case (r_state)
            ST_LOAD: begin
                r_ring_q   <= r_ring[r_rd_ptr];
                r_ring_vld <= r_valid[r_rd_ptr];
                r_diff     <= r_env - r_mag;
                r_acc      <= '0;
                r_rbit     <= 1'b0;
                r_coef_sh  <= r_coef;
            end
            ST_MUL: begin
                r_acc     <= w_mul_sum[ENV_W:1];
                r_rbit    <= w_mul_sum[0];
                r_coef_sh <= r_coef_sh >> 1;
            end
            ST_PREP: begin
                r_div <= w_div;
                r_num <= w_num;
                r_neg <= w_xd[SAMPLE_WIDTH-1];
                r_rem <= '0;
                r_quo <= '0;
                r_ovf <= 1'b0;
            end
            ST_DIV: begin
                r_rem <= w_ge ? w_trial_sub[ENV_W-1:0] : w_trial[ENV_W-1:0];
                r_num <= r_num << 1;
                r_quo <= {r_quo[SAMPLE_WIDTH-2:0], w_ge};
                r_ovf <= r_ovf | r_quo[SAMPLE_WIDTH-1];
            end
            default: ;
        endcase

        if (w_out_load) begin
            r_sample_out <= w_res;
            r_clipped    <= w_clip;
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

`ifndef NO_ASSERTIONS
    // An accepted sample always starts the ring read and envelope step next.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_LOAD))
        else $error("accepted sample did not start processing");

    // The envelope never exceeds ten times full scale.
    a_env_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= ENV_MAX)
        else $error("envelope above its largest value");

    // A release step never takes the envelope below the gained magnitude.
    a_release_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ENV) |=> (r_env >= r_mag))
        else $error("release dropped envelope below magnitude");

    // A zero divisor gives a zero, flagged result.
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_div == '0) |=>
            (o_out_valid && o_clipped && o_sample_out == '0))
        else $error("zero divisor result not zero and flagged");
`endif

endmodule
